### rtl/hdu_pkg.sv
// haversine distance unit package: fixed widths, scaling constants and cordic table
// used by haversine_distance_unit_core; no dependencies
package hdu_pkg;

    localparam int CORDIC_STAGES_DEF       = 24;
    localparam int ANGLE_FRACTION_BITS_DEF = 22;

    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int DIST_W = 22;

    // turns per degree, 2^40/360 rounded
    localparam logic [31:0] TURN_PER_DEG_Q40  = 32'd3054198966;
    localparam logic [31:0] CORDIC_START_Q30  = 32'd652032874;
    localparam logic [31:0] MILES_PER_TURN_Q8 = 32'd3260225875;
    localparam logic [30:0] UNIT_Q30          = 31'h4000_0000;

    // sqrt works on 62-bit radicands, one root bit per stage
    localparam int SQRT_STEPS = 31;

    // datapath widths of the cordic units
    localparam int CW = 34;

    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

### rtl/haversine_distance_unit_core.sv
// haversine great-circle distance unit, fully pipelined
// depends on hdu_pkg for widths, constants and the cordic arctangent table
//
// Takes a pair of points (degrees times 2^ANGLE_FRACTION_BITS) and returns the
// great-circle distance in miles times 2^8, rounded to nearest. One word is
// accepted every cycle while the output is not stalled; the pipeline is made of the
// rotation cordic (sines and cosines of four angles in parallel), the 31-stage
// square root pair and the vectoring cordic for the central angle. The whole
// pipeline stalls together while a finished word waits at the output.
module haversine_distance_unit_core #(
    parameter int CORDIC_STAGES       = hdu_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRACTION_BITS = hdu_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [hdu_pkg::LAT_W-1:0]   first_latitude,
    input  logic signed [hdu_pkg::LON_W-1:0]   first_longitude,
    input  logic signed [hdu_pkg::LAT_W-1:0]   second_latitude,
    input  logic signed [hdu_pkg::LON_W-1:0]   second_longitude,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [hdu_pkg::DIST_W-1:0]  distance_miles
);

    localparam int N       = CORDIC_STAGES;
    localparam int CW      = hdu_pkg::CW;
    localparam int SQ      = hdu_pkg::SQRT_STEPS;
    localparam int LAT     = 2 * N + 42;
    localparam int SH_HALF = 9 + ANGLE_FRACTION_BITS;
    localparam int SH_FULL = 8 + ANGLE_FRACTION_BITS;

    logic en;
    logic [LAT-1:0] vld_reg, vld_next;

    // angle differences and latitudes, lanes: dlat, dlon, lat1, lat2
    logic signed [32:0] d_reg [0:3];
    logic signed [32:0] d_next [0:3];
    logic signed [65:0] p_reg [0:3];
    logic signed [65:0] p_next [0:3];

    // rotation cordic
    logic signed [CW-1:0] cx_reg [0:N][0:3];
    logic signed [CW-1:0] cy_reg [0:N][0:3];
    logic signed [CW-1:0] ct_reg [0:N][0:3];
    logic                 cf_reg [0:N][0:3];
    logic signed [CW-1:0] cx_next [0:N][0:3];
    logic signed [CW-1:0] cy_next [0:N][0:3];
    logic signed [CW-1:0] ct_next [0:N][0:3];
    logic                 cf_next [0:N][0:3];

    logic signed [32:0] sn_reg [0:3];
    logic signed [32:0] cs_reg [0:3];

    logic signed [65:0] pa_reg, pb_reg, pc_reg;
    logic signed [32:0] ra_reg, rb_reg, rc_reg;
    logic signed [65:0] pd_reg;
    logic signed [32:0] ra2_reg;

    // square roots: lane 0 of hav, lane 1 of one minus hav
    logic [33:0] sr_reg [0:SQ][0:1];
    logic [30:0] sq_reg [0:SQ][0:1];
    logic [61:0] sn2_reg [0:SQ][0:1];
    logic [33:0] sr_next [0:SQ][0:1];
    logic [30:0] sq_next [0:SQ][0:1];
    logic [61:0] sn2_next [0:SQ][0:1];

    // vectoring cordic
    logic signed [CW-1:0] vx_reg [0:N];
    logic signed [CW-1:0] vy_reg [0:N];
    logic signed [CW-1:0] vz_reg [0:N];
    logic signed [CW-1:0] vx_next [0:N];
    logic signed [CW-1:0] vy_next [0:N];
    logic signed [CW-1:0] vz_next [0:N];

    logic [62:0] dp_reg, dp_next;
    logic [hdu_pkg::DIST_W-1:0] dist_reg, dist_next;

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];
    assign distance_miles = dist_reg;
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_comb
    begin
        d_next[0] = {{3{second_latitude[29]}}, second_latitude}
                  - {{3{first_latitude[29]}}, first_latitude};
        d_next[1] = {{2{second_longitude[30]}}, second_longitude}
                  - {{2{first_longitude[30]}}, first_longitude};
        d_next[2] = {{3{first_latitude[29]}}, first_latitude};
        d_next[3] = {{3{second_latitude[29]}}, second_latitude};
        for (int l = 0; l < 4; l++)
        begin
            p_next[l] = {{33{d_reg[l][32]}}, d_reg[l]}
                      * $signed({34'd0, hdu_pkg::TURN_PER_DEG_Q40});
        end
    end

    // binary angle, fold into the right half plane, then cordic rotation
    always_comb
    begin
        logic signed [65:0] sum;
        logic signed [65:0] shd;
        logic        [31:0] ang;
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] qt;
        for (int l = 0; l < 4; l++)
        begin
            if (l < 2)
            begin
                sum = p_reg[l] + (66'sd1 <<< (SH_HALF - 1));
                shd = sum >>> SH_HALF;
            end
            else
            begin
                sum = p_reg[l] + (66'sd1 <<< (SH_FULL - 1));
                shd = sum >>> SH_FULL;
            end
            ang = shd[31:0];
            t   = {{(CW-32){ang[31]}}, ang};
            qt  = CW'(34'sd1 <<< 30);
            cx_next[0][l] = $signed({{(CW-32){1'b0}}, hdu_pkg::CORDIC_START_Q30});
            cy_next[0][l] = '0;
            if (t > qt)
            begin
                ct_next[0][l] = t - (qt <<< 1);
                cf_next[0][l] = 1'b1;
            end
            else if (t < -qt)
            begin
                ct_next[0][l] = t + (qt <<< 1);
                cf_next[0][l] = 1'b1;
            end
            else
            begin
                ct_next[0][l] = t;
                cf_next[0][l] = 1'b0;
            end
        end
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                cf_next[k+1][l] = cf_reg[k][l];
                if (ct_reg[k][l] >= 0)
                begin
                    cx_next[k+1][l] = cx_reg[k][l] - (cy_reg[k][l] >>> k);
                    cy_next[k+1][l] = cy_reg[k][l] + (cx_reg[k][l] >>> k);
                    ct_next[k+1][l] = ct_reg[k][l]
                                    - $signed({2'b00, hdu_pkg::atan_turns(k)});
                end
                else
                begin
                    cx_next[k+1][l] = cx_reg[k][l] + (cy_reg[k][l] >>> k);
                    cy_next[k+1][l] = cy_reg[k][l] - (cx_reg[k][l] >>> k);
                    ct_next[k+1][l] = ct_reg[k][l]
                                    + $signed({2'b00, hdu_pkg::atan_turns(k)});
                end
            end
        end
    end

    // haversine term, clamp, square root seeds
    always_comb
    begin
        logic signed [65:0] rd;
        logic signed [33:0] hs;
        logic        [30:0] hav;
        rd  = (pd_reg + (66'sd1 <<< 29)) >>> 30;
        hs  = {ra2_reg[32], ra2_reg} + rd[33:0];
        if (hs < 0)
            hav = '0;
        else if (hs > $signed({3'b000, hdu_pkg::UNIT_Q30}))
            hav = hdu_pkg::UNIT_Q30;
        else
            hav = hs[30:0];
        sr_next[0][0]  = '0;
        sq_next[0][0]  = '0;
        sn2_next[0][0] = {1'b0, hav, 30'd0};
        sr_next[0][1]  = '0;
        sq_next[0][1]  = '0;
        sn2_next[0][1] = {1'b0, hdu_pkg::UNIT_Q30 - hav, 30'd0};
        for (int k = 0; k < SQ; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                logic [33:0] cur;
                logic [33:0] trial;
                cur   = {sr_reg[k][l][31:0], sn2_reg[k][l][61:60]};
                trial = {1'b0, sq_reg[k][l], 2'b01};
                sn2_next[k+1][l] = {sn2_reg[k][l][59:0], 2'b00};
                if (cur >= trial)
                begin
                    sr_next[k+1][l] = cur - trial;
                    sq_next[k+1][l] = {sq_reg[k][l][29:0], 1'b1};
                end
                else
                begin
                    sr_next[k+1][l] = cur;
                    sq_next[k+1][l] = {sq_reg[k][l][29:0], 1'b0};
                end
            end
        end
    end

    // central half angle by vectoring, then scale to miles
    always_comb
    begin
        logic [30:0] zc;
        vx_next[0] = $signed({{(CW-31){1'b0}}, sq_reg[SQ][1]});
        vy_next[0] = $signed({{(CW-31){1'b0}}, sq_reg[SQ][0]});
        vz_next[0] = '0;
        for (int k = 0; k < N; k++)
        begin
            if (vy_reg[k] > 0)
            begin
                vx_next[k+1] = vx_reg[k] + (vy_reg[k] >>> k);
                vy_next[k+1] = vy_reg[k] - (vx_reg[k] >>> k);
                vz_next[k+1] = vz_reg[k] + $signed({2'b00, hdu_pkg::atan_turns(k)});
            end
            else
            begin
                vx_next[k+1] = vx_reg[k] - (vy_reg[k] >>> k);
                vy_next[k+1] = vy_reg[k] + (vx_reg[k] >>> k);
                vz_next[k+1] = vz_reg[k] - $signed({2'b00, hdu_pkg::atan_turns(k)});
            end
        end
        if (vz_reg[N] < 0)
            zc = '0;
        else if (vz_reg[N] > $signed({{(CW-31){1'b0}}, hdu_pkg::UNIT_Q30}))
            zc = hdu_pkg::UNIT_Q30;
        else
            zc = vz_reg[N][30:0];
        dp_next   = {32'd0, zc} * {31'd0, hdu_pkg::MILES_PER_TURN_Q8};
        dist_next = 22'((dp_reg + (63'd1 << 39)) >> 40);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        logic signed [65:0] rv;
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                d_reg[l]  <= d_next[l];
                p_reg[l]  <= p_next[l];
                sn_reg[l] <= cf_reg[N][l] ? -cy_reg[N][l][32:0] : cy_reg[N][l][32:0];
                cs_reg[l] <= cf_reg[N][l] ? -cx_reg[N][l][32:0] : cx_reg[N][l][32:0];
            end
            for (int k = 0; k <= N; k++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    cx_reg[k][l] <= cx_next[k][l];
                    cy_reg[k][l] <= cy_next[k][l];
                    ct_reg[k][l] <= ct_next[k][l];
                    cf_reg[k][l] <= cf_next[k][l];
                end
                vx_reg[k] <= vx_next[k];
                vy_reg[k] <= vy_next[k];
                vz_reg[k] <= vz_next[k];
            end
            pa_reg <= {{33{sn_reg[0][32]}}, sn_reg[0]} * {{33{sn_reg[0][32]}}, sn_reg[0]};
            pb_reg <= {{33{cs_reg[2][32]}}, cs_reg[2]} * {{33{cs_reg[3][32]}}, cs_reg[3]};
            pc_reg <= {{33{sn_reg[1][32]}}, sn_reg[1]} * {{33{sn_reg[1][32]}}, sn_reg[1]};
            rv = (pa_reg + (66'sd1 <<< 29)) >>> 30;
            ra_reg <= rv[32:0];
            rv = (pb_reg + (66'sd1 <<< 29)) >>> 30;
            rb_reg <= rv[32:0];
            rv = (pc_reg + (66'sd1 <<< 29)) >>> 30;
            rc_reg <= rv[32:0];
            pd_reg  <= {{33{rb_reg[32]}}, rb_reg} * {{33{rc_reg[32]}}, rc_reg};
            ra2_reg <= ra_reg;
            for (int k = 0; k <= SQ; k++)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    sr_reg[k][l]  <= sr_next[k][l];
                    sq_reg[k][l]  <= sq_next[k][l];
                    sn2_reg[k][l] <= sn2_next[k][l];
                end
            end
            dp_reg   <= dp_next;
            dist_reg <= dist_next;
        end
    end

endmodule
